// ===== hw/rtl/imhdk_pkg.sv =====
package imhdk_pkg;

  localparam int HEAP_DEPTH = 1024;
  localparam int KEY_BITS   = 32;
  localparam int ID_BITS    = 10;
  localparam int SLOT_BITS  = $clog2(HEAP_DEPTH);
  localparam int CNT_BITS   = $clog2(HEAP_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_INSERT   = 2'd0,
    ACT_DECREASE = 2'd1,
    ACT_EXTRACT  = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_ABSENT    = 3'd4,
    ST_NOT_LESS  = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [ID_BITS-1:0] item_id;
    logic signed [31:0] item_key;
  } in_item_t;

  typedef struct packed {
    logic [ID_BITS-1:0] result_id;
    logic signed [31:0] result_key;
    logic [10:0]        heap_count;
    logic [2:0]         status;
  } out_item_t;

  typedef struct packed {
    logic [ID_BITS-1:0]  id;
    logic [KEY_BITS-1:0] key;
  } slot_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RD_PRES,
    S_CHECK,
    S_DEC_RD,
    S_DEC_CHK,
    S_UP_RD,
    S_UP_CMP,
    S_UP_W2,
    S_EX_RD,
    S_EX_LAST,
    S_EX_ROOT,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMP,
    S_DN_W2,
    S_ROOT_RD,
    S_ROOT,
    S_OUT
  } fsm_t;

  function automatic logic key_less(input logic [KEY_BITS-1:0] a,
                                    input logic [KEY_BITS-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

// ===== hw/rtl/imhdk_slot_ram.sv =====
module imhdk_slot_ram
  import imhdk_pkg::*;
(
  input  logic                 clk,
  input  logic                 we,
  input  logic [SLOT_BITS-1:0] waddr,
  input  slot_t                wdata,
  input  logic [SLOT_BITS-1:0] raddr,
  output slot_t                rdata
);
  slot_t mem [HEAP_DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/imhdk_index_ram.sv =====
module imhdk_index_ram
  import imhdk_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 we,
  input  logic [ID_BITS-1:0]   waddr,
  input  logic [SLOT_BITS-1:0] wpos,
  input  logic                 pres_we,
  input  logic [ID_BITS-1:0]   pres_addr,
  input  logic                 pres_val,
  input  logic [ID_BITS-1:0]   raddr,
  output logic [SLOT_BITS-1:0] rpos,
  output logic                 rpresent,
  output logic                 busy
);
  // position store and presence flags; a pass after reset clears the flags
  logic [SLOT_BITS-1:0] pos_mem [1 << ID_BITS];
  logic                 pres_mem [1 << ID_BITS];
  logic [ID_BITS:0]     clr_r;

  assign busy = !clr_r[ID_BITS];

  always_ff @(posedge clk) begin
    if (we) pos_mem[waddr] <= wpos;
    rpos <= pos_mem[raddr];
  end

  // clear counter walks every id once after reset
  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (busy) clr_r <= clr_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (busy) pres_mem[clr_r[ID_BITS-1:0]] <= 1'b0;
    else if (pres_we) pres_mem[pres_addr] <= pres_val;
    rpresent <= pres_mem[raddr];
  end
endmodule

// ===== hw/rtl/indexed_min_heap_decrease_key.sv =====
// indexed binary min-heap with decrease-key
// input channel in_valid/in_ready/in_data carries one action per beat:
//   insert, decrease key or extract minimum (in_item_t)
// result channel out_valid/out_ready/out_data returns exactly one beat
//   per input beat: popped entry on extract, else root after the action,
//   plus the entry count and a status code
// one item at a time; inserts and decreases sift up through S_UP_RD,
//   S_UP_CMP and S_UP_W2 for each level moved up; an extract reads the
//   root and the last entry, then sifts down through S_DN_RDL, S_DN_RDR,
//   S_DN_CMP and S_DN_W2 for each level; the single read port of the slot
//   memory sets these steps
// reset clears the count and control, then a pass over all 1024 ids clears
//   the presence flags while in_ready stays low; slot and position memories
//   need no clearing since only live entries are read
// a result waits in the output register while out_ready is low; the next
//   input beat is taken once out_valid has dropped and the FSM is idle again
module indexed_min_heap_decrease_key
  import imhdk_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  fsm_t state_r, state_nxt;

  in_item_t             item_r;
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic [SLOT_BITS-1:0] cur_r, cur_nxt;      // slot being sifted
  logic [SLOT_BITS-1:0] oth_r, oth_nxt;      // parent or chosen child
  slot_t                cur_d_r, cur_d_nxt;  // entry moving through the heap
  slot_t                oth_d_r, oth_d_nxt;
  logic                 rch_r, rch_nxt;      // right child in range
  status_t              st_r, st_nxt;
  out_item_t            out_r;
  logic                 out_valid_r;

  // slot memory ports
  logic                 s_we;
  logic [SLOT_BITS-1:0] s_waddr, s_raddr;
  slot_t                s_wdata, s_rdata;
  // index memory ports
  logic                 p_we, pr_we, pr_val;
  logic [ID_BITS-1:0]   p_waddr, pr_addr, p_raddr;
  logic [SLOT_BITS-1:0] p_wpos, p_rpos;
  logic                 p_rpres;
  logic                 p_busy;              // presence clearing after reset

  imhdk_slot_ram u_slot (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  imhdk_index_ram u_index (
    .clk(clk), .rst_n(rst_n), .we(p_we), .waddr(p_waddr), .wpos(p_wpos),
    .pres_we(pr_we), .pres_addr(pr_addr), .pres_val(pr_val),
    .raddr(p_raddr), .rpos(p_rpos), .rpresent(p_rpres), .busy(p_busy)
  );

  assign in_ready  = (state_r == S_IDLE) && !p_busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  logic [SLOT_BITS:0] l_ext, r_ext;
  logic [SLOT_BITS-1:0] par;
  slot_t new_ent;

  always_comb begin
    l_ext   = {cur_r, 1'b1};
    r_ext   = {cur_r, 1'b0} + (SLOT_BITS+1)'(2);
    par     = (cur_r - 1'b1) >> 1;
    new_ent = '{id: item_r.item_id, key: KEY_BITS'(item_r.item_key)};
  end

  // the moving entry on a sift down is parked in its final slot at exit
  logic dn_park;
  assign dn_park = (state_r == S_OUT) && (item_r.action == ACT_EXTRACT) &&
                   (st_r == ST_OK) && !out_valid_r && (cnt_r != '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_valid && in_ready) state_nxt = S_RD_PRES;
      S_RD_PRES: state_nxt = S_CHECK;
      S_CHECK: begin
        case (item_r.action)
          ACT_INSERT:
            if (p_rpres || cnt_r >= CNT_BITS'(HEAP_DEPTH)) state_nxt = S_ROOT_RD;
            else state_nxt = (cnt_r == '0) ? S_ROOT_RD : S_UP_RD;
          ACT_DECREASE: state_nxt = p_rpres ? S_DEC_RD : S_ROOT_RD;
          ACT_EXTRACT:  state_nxt = (cnt_r == '0) ? S_ROOT_RD : S_EX_RD;
          default:      state_nxt = S_ROOT_RD;
        endcase
      end
      S_DEC_RD:  state_nxt = S_DEC_CHK;
      S_DEC_CHK:
        if (!key_less(new_ent.key, s_rdata.key)) state_nxt = S_ROOT_RD;
        else state_nxt = (cur_r == '0) ? S_ROOT_RD : S_UP_RD;
      S_UP_RD:   state_nxt = S_UP_CMP;
      S_UP_CMP:  state_nxt = key_less(cur_d_r.key, s_rdata.key) ? S_UP_W2 : S_ROOT_RD;
      S_UP_W2:   state_nxt = (oth_r == '0) ? S_ROOT_RD : S_UP_RD;
      S_EX_RD:   state_nxt = S_EX_LAST;
      S_EX_LAST: state_nxt = S_EX_ROOT;
      S_EX_ROOT: state_nxt = (cnt_r == '0) ? S_OUT : S_DN_RDL;
      S_DN_RDL:
        if (l_ext >= (SLOT_BITS+1)'(cnt_r)) state_nxt = S_OUT;
        else state_nxt = S_DN_RDR;
      S_DN_RDR:  state_nxt = S_DN_CMP;
      S_DN_CMP:  state_nxt = S_DN_W2;
      S_DN_W2:   state_nxt = (oth_r == cur_r) ? S_OUT : S_DN_RDL;
      S_ROOT_RD: state_nxt = S_ROOT;
      S_ROOT:    state_nxt = S_OUT;
      S_OUT:     if (!out_valid_r) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cnt_nxt = cnt_r; cur_nxt = cur_r; oth_nxt = oth_r;
    cur_d_nxt = cur_d_r; oth_d_nxt = oth_d_r; rch_nxt = rch_r; st_nxt = st_r;
    s_we = 1'b0; s_waddr = cur_r; s_wdata = cur_d_r; s_raddr = '0;
    p_we = 1'b0; p_waddr = cur_d_r.id; p_wpos = cur_r;
    pr_we = 1'b0; pr_addr = item_r.item_id; pr_val = 1'b1;
    p_raddr = item_r.item_id;
    case (state_r)
      S_CHECK: begin
        st_nxt = ST_OK;
        case (item_r.action)
          ACT_INSERT:
            if (p_rpres) st_nxt = ST_DUPLICATE;
            else if (cnt_r >= CNT_BITS'(HEAP_DEPTH)) st_nxt = ST_FULL;
            else begin
              cur_nxt = SLOT_BITS'(cnt_r);
              cur_d_nxt = new_ent;
              s_we = 1'b1; s_waddr = SLOT_BITS'(cnt_r); s_wdata = new_ent;
              p_we = 1'b1; p_waddr = item_r.item_id; p_wpos = SLOT_BITS'(cnt_r);
              pr_we = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
            end
          ACT_DECREASE: begin
            if (!p_rpres) st_nxt = ST_ABSENT;
            cur_nxt = p_rpos;
          end
          ACT_EXTRACT: if (cnt_r == '0) st_nxt = ST_EMPTY;
          default: ;
        endcase
      end
      S_DEC_RD: s_raddr = cur_r;
      S_DEC_CHK:
        if (!key_less(new_ent.key, s_rdata.key)) st_nxt = ST_NOT_LESS;
        else begin
          cur_d_nxt = new_ent;
          s_we = 1'b1; s_wdata = new_ent;
        end
      S_UP_RD: begin
        s_raddr = par; oth_nxt = par;
      end
      S_UP_CMP: begin
        oth_d_nxt = s_rdata;
        if (key_less(cur_d_r.key, s_rdata.key)) begin
          // parent moves down into the current slot
          s_we = 1'b1; s_waddr = cur_r; s_wdata = s_rdata;
          p_we = 1'b1; p_waddr = s_rdata.id; p_wpos = cur_r;
        end
      end
      S_UP_W2: begin
        s_we = 1'b1; s_waddr = oth_r; s_wdata = cur_d_r;
        p_we = 1'b1; p_waddr = cur_d_r.id; p_wpos = oth_r;
        cur_nxt = oth_r;
      end
      S_EX_RD: s_raddr = '0;
      S_EX_LAST: begin
        oth_d_nxt = s_rdata;                    // popped root
        pr_we = 1'b1; pr_addr = s_rdata.id; pr_val = 1'b0;
        s_raddr = SLOT_BITS'(cnt_r - 1'b1);
        cnt_nxt = cnt_r - 1'b1;
      end
      S_EX_ROOT: begin
        cur_nxt = '0;
        cur_d_nxt = s_rdata;
        if (cnt_r != '0) begin
          s_we = 1'b1; s_waddr = '0; s_wdata = s_rdata;
          p_we = 1'b1; p_waddr = s_rdata.id; p_wpos = '0;
        end
      end
      S_DN_RDL: begin
        s_raddr = SLOT_BITS'(l_ext);
        rch_nxt = r_ext < (SLOT_BITS+1)'(cnt_r);
        oth_nxt = cur_r;
      end
      S_DN_RDR: begin
        s_raddr = SLOT_BITS'(r_ext);
        if (key_less(s_rdata.key, cur_d_r.key)) begin
          oth_nxt = SLOT_BITS'(l_ext); oth_d_nxt = s_rdata;
        end else oth_d_nxt = cur_d_r;
      end
      S_DN_CMP:
        if (rch_r && key_less(s_rdata.key, oth_d_r.key)) begin
          oth_nxt = SLOT_BITS'(r_ext); oth_d_nxt = s_rdata;
        end
      S_DN_W2:
        if (oth_r != cur_r) begin
          // child moves up, moving entry goes down (parked when the walk ends)
          s_we = 1'b1; s_waddr = cur_r; s_wdata = oth_d_r;
          p_we = 1'b1; p_waddr = oth_d_r.id; p_wpos = cur_r;
          cur_nxt = oth_r;
        end
      S_ROOT_RD: s_raddr = '0;
      S_ROOT: oth_d_nxt = s_rdata;
      S_OUT:
        if (dn_park) begin
          s_we = 1'b1; s_waddr = cur_r; s_wdata = cur_d_r;
          p_we = 1'b1; p_waddr = cur_d_r.id; p_wpos = cur_r;
        end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (state_r == S_ROOT ||
          (state_r == S_EX_ROOT && cnt_r == '0) ||
          (state_r == S_DN_RDL && l_ext >= (SLOT_BITS+1)'(cnt_r)) ||
          (state_r == S_DN_W2 && oth_r == cur_r))
        out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item_r <= in_data;
    cur_r <= cur_nxt; oth_r <= oth_nxt; cur_d_r <= cur_d_nxt;
    oth_d_r <= oth_d_nxt; rch_r <= rch_nxt; st_r <= st_nxt;
    if (state_r == S_ROOT) begin
      out_r.result_id  <= (cnt_r == '0) ? '0 : s_rdata.id;
      out_r.result_key <= (cnt_r == '0) ? '0 : 32'(signed'(s_rdata.key));
      out_r.heap_count <= 11'(cnt_r);
      out_r.status     <= st_r;
    end else if (state_r == S_EX_ROOT) begin
      // popped entry is captured before the sift down reuses oth_d_r
      out_r.result_id  <= oth_d_r.id;
      out_r.result_key <= 32'(signed'(oth_d_r.key));
      out_r.heap_count <= 11'(cnt_r);
      out_r.status     <= ST_OK;
    end
  end

endmodule

// ===== hw/rtl/imhdk_checker.sv =====
module imhdk_checker
  import imhdk_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed under stall");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= 3'd5)
    else $error("bad status code");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.heap_count <= 11'(HEAP_DEPTH))
    else $error("count beyond depth");
endmodule

bind indexed_min_heap_decrease_key imhdk_checker u_imhdk_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import imhdk_pkg::*;

  localparam int LIMIT = 1000000;
  localparam logic signed [31:0] KMAX = 32'sh7fffffff;
  localparam logic signed [31:0] KMIN = 32'sh80000000;

  // mix selectors for the random generator
  localparam int MIX_RANDOM = 0;
  localparam int MIX_FILL   = 1;
  localparam int MIX_DRAIN  = 2;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  indexed_min_heap_decrease_key dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data
  );

  always #5 clk = ~clk;

  // shadow heap: slot contents, id index, presence and count
  logic signed [31:0] sh_key [HEAP_DEPTH];
  logic [9:0]         sh_id  [HEAP_DEPTH];
  logic [9:0]         sh_pos [1024];
  bit                 sh_present [1024];
  int                 sh_count = 0;

  out_item_t expected_results[$];
  int        errs = 0;
  int        cycles = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  bit        pressure_on = 1'b0;

  function automatic void swap_slot(int a, int b);
    logic signed [31:0] k;
    logic [9:0] d;
    k = sh_key[a]; d = sh_id[a];
    sh_key[a] = sh_key[b]; sh_id[a] = sh_id[b];
    sh_key[b] = k; sh_id[b] = d;
    sh_pos[sh_id[a]] = a[9:0];
    sh_pos[sh_id[b]] = b[9:0];
  endfunction

  function automatic void bubble_up(int i);
    int p;
    while (i != 0) begin
      p = (i - 1) / 2;
      if (!(sh_key[i] < sh_key[p])) break;
      swap_slot(p, i);
      i = p;
    end
  endfunction

  function automatic void bubble_down(int i);
    int m, l, r;
    forever begin
      m = i; l = 2 * i + 1; r = 2 * i + 2;
      // left is checked first so it wins a tie with the right child
      if (l < sh_count && sh_key[l] < sh_key[m]) m = l;
      if (r < sh_count && sh_key[r] < sh_key[m]) m = r;
      if (m == i) break;
      swap_slot(i, m);
      i = m;
    end
  endfunction

  // applies one action to the shadow heap and returns the beat it produces
  function automatic out_item_t heap_apply(in_item_t it);
    out_item_t o;
    bit popped;
    int i;
    o = '0;
    o.status = ST_OK;
    popped = 1'b0;
    case (it.action)
      ACT_INSERT: begin
        if (sh_present[it.item_id]) o.status = ST_DUPLICATE;
        else if (sh_count >= HEAP_DEPTH) o.status = ST_FULL;
        else begin
          i = sh_count;
          sh_key[i] = it.item_key;
          sh_id[i] = it.item_id;
          sh_pos[it.item_id] = i[9:0];
          sh_present[it.item_id] = 1'b1;
          sh_count++;
          bubble_up(i);
        end
      end
      ACT_DECREASE: begin
        if (!sh_present[it.item_id]) o.status = ST_ABSENT;
        else begin
          i = sh_pos[it.item_id];
          if (!(it.item_key < sh_key[i])) o.status = ST_NOT_LESS;
          else begin
            sh_key[i] = it.item_key;
            bubble_up(i);
          end
        end
      end
      ACT_EXTRACT: begin
        if (sh_count == 0) o.status = ST_EMPTY;
        else begin
          popped = 1'b1;
          o.result_id = sh_id[0];
          o.result_key = sh_key[0];
          sh_present[sh_id[0]] = 1'b0;
          sh_count--;
          if (sh_count != 0) begin
            sh_key[0] = sh_key[sh_count];
            sh_id[0] = sh_id[sh_count];
            sh_pos[sh_id[0]] = '0;
            bubble_down(0);
          end
        end
      end
      default: ;
    endcase
    if (!popped && sh_count != 0) begin
      o.result_id = sh_id[0];
      o.result_key = sh_key[0];
    end
    o.heap_count = sh_count[10:0];
    return o;
  endfunction

  // key mix: extremes, a narrow band for ties, and full range
  function automatic logic signed [31:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return KMIN;
    if (r < 16) return KMAX;
    if (r < 50) return $signed(32'($urandom_range(0, 40))) - 32'sd20;
    return $signed($urandom());
  endfunction

  function automatic logic [9:0] absent_id();
    int s;
    s = $urandom_range(0, 1023);
    for (int n = 0; n < 1024; n++)
      if (!sh_present[(s + n) % 1024]) return 10'((s + n) % 1024);
    return 10'(s);
  endfunction

  function automatic in_item_t decrease_item();
    in_item_t it;
    longint nk;
    it.action = ACT_DECREASE;
    it.item_id = sh_id[$urandom_range(0, sh_count - 1)];
    nk = longint'(sh_key[sh_pos[it.item_id]]);
    // mostly a real decrease, sometimes equal or larger
    if ($urandom_range(0, 9) == 0) nk = nk + $urandom_range(0, 3);
    else if ($urandom_range(0, 4) == 0) nk = nk - $urandom();
    else nk = nk - $urandom_range(1, 50);
    if (nk < longint'(KMIN)) nk = longint'(KMIN);
    if (nk > longint'(KMAX)) nk = longint'(KMAX);
    it.item_key = 32'(nk);
    return it;
  endfunction

  function automatic in_item_t make_item(int mix);
    in_item_t it;
    int r;
    r = $urandom_range(0, 99);
    it.item_id = 10'($urandom());
    it.item_key = pick_key();
    if (r < 4) begin
      // noise: any action code, any id
      it.action = 2'($urandom());
      return it;
    end
    if (mix == MIX_FILL) r = (r < 90) ? 0 : (r < 97 ? 50 : 90);
    if (mix == MIX_DRAIN) r = (r < 80) ? 90 : (r < 95 ? 50 : 0);
    if (r < 40) begin
      it.action = ACT_INSERT;
      if (sh_count < HEAP_DEPTH) it.item_id = absent_id();
    end else if (r < 75 && sh_count > 0) begin
      it = decrease_item();
    end else begin
      it.action = ACT_EXTRACT;
    end
    return it;
  endfunction

  // offers one beat and holds it until accepted, then updates the shadow heap
  task automatic send(in_item_t it, bit typed, out_item_t typed_exp);
    out_item_t got;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    got = heap_apply(it);
    expected_results.push_back(typed ? typed_exp : got);
    @(negedge clk);
  endtask

  task automatic row(action_t a, int id, logic signed [31:0] k, bit typed,
                     int eid, logic signed [31:0] ek, int ecnt, status_t est);
    in_item_t it;
    out_item_t e;
    it.action = a; it.item_id = id[9:0]; it.item_key = k;
    e.result_id = eid[9:0]; e.result_key = ek;
    e.heap_count = ecnt[10:0]; e.status = est;
    send(it, typed, e);
  endtask

  task automatic random_run(int n, int mix);
    for (int k = 0; k < n; k++) send(make_item(mix), 1'b0, '0);
  endtask

  // receiver: random stalls, plus a long hold whenever pressure_on toggles
  initial begin
    int hold;
    bit last_p;
    hold = 0;
    last_p = 1'b0;
    forever begin
      @(negedge clk);
      if (pressure_on != last_p) begin
        last_p = pressure_on;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // result checker, oldest expectation first
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result beat id=%0d key=%0d", out_data.result_id,
               out_data.result_key);
        errs++;
      end else begin
        e = expected_results.pop_front();
        if (out_data.result_id !== e.result_id) begin
          $error("result_id expected %0d actual %0d", e.result_id, out_data.result_id);
          errs++;
        end
        if (out_data.result_key !== e.result_key) begin
          $error("result_key expected %0d actual %0d", e.result_key, out_data.result_key);
          errs++;
        end
        if (out_data.heap_count !== e.heap_count) begin
          $error("heap_count expected %0d actual %0d", e.heap_count, out_data.heap_count);
          errs++;
        end
        if (out_data.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_data.status);
          errs++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    int guard;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, no idling
    row(ACT_EXTRACT, 0, 0, 1, 0, 0, 0, ST_EMPTY);          // extract on empty
    row(ACT_DECREASE, 7, 0, 1, 0, 0, 0, ST_ABSENT);        // absent id
    row(ACT_NONE, 3, 0, 1, 0, 0, 0, ST_OK);                // unused code, empty root
    row(ACT_INSERT, 5, KMAX, 1, 5, KMAX, 1, ST_OK);
    row(ACT_INSERT, 5, 0, 1, 5, KMAX, 1, ST_DUPLICATE);
    row(ACT_INSERT, 1023, KMIN, 1, 1023, KMIN, 2, ST_OK);
    row(ACT_DECREASE, 1023, KMIN, 1, 1023, KMIN, 2, ST_NOT_LESS);
    row(ACT_DECREASE, 5, KMAX, 1, 1023, KMIN, 2, ST_NOT_LESS); // equal key
    row(ACT_INSERT, 0, -1, 0, 0, 0, 0, ST_OK);
    row(ACT_INSERT, 512, -1, 0, 0, 0, 0, ST_OK);            // tie with sibling
    row(ACT_INSERT, 300, 100, 0, 0, 0, 0, ST_OK);
    row(ACT_INSERT, 301, 100, 0, 0, 0, 0, ST_OK);
    row(ACT_DECREASE, 5, 99, 0, 0, 0, 0, ST_OK);            // no sift up, parent is smaller
    row(ACT_DECREASE, 301, KMIN, 0, 0, 0, 0, ST_OK);        // moves up, then ties root, no swap
    row(ACT_DECREASE, 300, 32'sh7ffffffe, 0, 0, 0, 0, ST_OK);
    row(ACT_NONE, 1023, KMAX, 0, 0, 0, 0, ST_OK);
    for (int k = 0; k < 6; k++) row(ACT_EXTRACT, 0, 0, 0, 0, 0, 0, ST_OK);
    row(ACT_EXTRACT, 9, KMAX, 1, 0, 0, 0, ST_EMPTY);        // drained again

    // random mix with a sender that idles, long receiver hold partway
    send_idle_pct = 71;
    random_run(40, MIX_RANDOM);
    send_idle_pct = 0;
    pressure_on = 1'b1;
    random_run(100, MIX_RANDOM);

    // fill to full depth with a stalling receiver
    recv_stall_pct = 71;
    guard = 0;
    while (sh_count < HEAP_DEPTH && guard < 1300) begin
      send(make_item(MIX_FILL), 1'b0, '0);
      guard++;
    end

    // at full depth: every id is present, so inserts are duplicates
    send_idle_pct = 31;
    recv_stall_pct = 31;
    random_run(100, MIX_RANDOM);

    // drain partway, no idling
    send_idle_pct = 0;
    recv_stall_pct = 0;
    guard = 0;
    while (sh_count > 0 && guard < 480) begin
      send(make_item(MIX_DRAIN), 1'b0, '0);
      guard++;
    end
    row(ACT_EXTRACT, 0, 0, 0, 0, 0, 0, ST_OK);
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errs == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule
